>>> rtl/hsj_pkg.sv
// Shared types, constants and fixed-point helpers for the Hermite stencil Jacobian block.
// No dependencies; the top level and the checker import this package.
`default_nettype none
package hsj_pkg;

  localparam int GRID_MAX  = 64;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = $clog2(GRID_MAX);
  localparam int N_W       = CNT_W + 1;

  localparam logic [30:0] REYNOLDS_RST    = 31'd327680;
  localparam logic [30:0] INV_SPACING_RST = 31'd2031616;
  localparam logic [6:0]  GRID_SIZE_RST   = 7'd32;

  typedef logic signed [31:0] q_t;
  typedef logic signed [47:0] prod_t;

  typedef enum logic [1:0] {
    CFG_REYNOLDS    = 2'd0,
    CFG_INV_SPACING = 2'd1,
    CFG_GRID_SIZE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic first_node;
    q_t   stream_value;
    q_t   stream_slope_x;
    q_t   stream_slope_y;
    q_t   stream_cross;
    q_t   vort_value;
    q_t   vort_slope_x;
    q_t   vort_slope_y;
    q_t   vort_cross;
  } in_t;

  typedef struct packed {
    q_t sv;
    q_t sx;
    q_t sy;
    q_t sc;
    q_t vv;
    q_t vx;
    q_t vy;
    q_t vc;
  } node_t;

  typedef struct packed {
    q_t         force_value;
    q_t         force_slope_x;
    q_t         force_slope_y;
    q_t         force_cross;
    logic [5:0] center_row;
    logic [5:0] center_col;
    logic       last_of_grid;
  } out_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } meta_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // exact product, floored by the fraction width
  function automatic logic signed [63:0] qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hsj_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
`default_nettype none
module hsj_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/hermite_stencil_jacobian_force.sv
// Hermite stencil Jacobian forcing: top level with line stores and arithmetic pipeline.
// Depends on hsj_pkg and hsj_ram.
//
// Nodes enter in row-major order, one beat per clock when nothing downstream stalls.
// Two line RAMs hold alternate rows (even rows, odd rows); on each accepted beat the
// block writes the node into its own row's RAM, reads the same column of that RAM
// (the row two above, read before overwrite) and reads column+1 of the other RAM
// (the row above). A two-entry window of the row above plus a saved column-0 entry
// per row give the west, centre and east neighbours. An accepted node passes through
// stage registers B to H into the output register; the sustained rate is one node per
// cycle when nothing stalls, set by the single write and single read port of each line
// RAM. Boundary nodes are stored but give no result beat. Results wait in the output
// register while out_stall is high; the stages behind it keep filling until they are
// full, and only then is in_stall raised. Configuration writes are always taken
// (cfg_ready is tied high) and must happen while the block is idle. The line RAMs are
// not cleared after reset; within a grid every entry feeding a result has been written.
`default_nettype none
module hermite_stencil_jacobian_force import hsj_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  // ---------------- configuration ----------------
  logic [30:0] reynolds_r, inv_spacing_r;
  logic [6:0]  grid_size_r;
  logic [N_W-1:0] grid_n;
  q_t ihq, req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reynolds_r    <= REYNOLDS_RST;
      inv_spacing_r <= INV_SPACING_RST;
      grid_size_r   <= GRID_SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REYNOLDS:    reynolds_r    <= cfg_data;
        CFG_INV_SPACING: inv_spacing_r <= cfg_data;
        CFG_GRID_SIZE:   grid_size_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamp the grid side to 3..GRID_MAX
  always_comb begin
    if (N_W'(grid_size_r) < N_W'(3)) grid_n = N_W'(3);
    else if (N_W'(grid_size_r) > N_W'(GRID_MAX)) grid_n = N_W'(GRID_MAX);
    else grid_n = N_W'(grid_size_r);
  end

  assign ihq = {1'b0, inv_spacing_r};
  assign req = {1'b0, reynolds_r};

  // ---------------- pipeline handshake ----------------
  logic v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, v_g_r, v_h_r, out_valid_r;
  logic rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h, rdy_o;
  logic accept;

  assign rdy_o  = !out_valid_r || !out_stall;
  assign rdy_h  = !v_h_r || rdy_o;
  assign rdy_g  = !v_g_r || rdy_h;
  assign rdy_f  = !v_f_r || rdy_g;
  assign rdy_e  = !v_e_r || rdy_f;
  assign rdy_d  = !v_d_r || rdy_e;
  assign rdy_c  = !v_c_r || rdy_d;
  assign rdy_b  = !v_b_r || rdy_c;
  assign accept = in_valid && rdy_b;
  assign in_stall = !rdy_b;

  // ---------------- position counters ----------------
  logic [CNT_W-1:0] row_r, col_r, row_nxt, col_nxt, r_cur, c_cur;
  logic [N_W-1:0]   r_w, c_w;
  logic             interior, last_node;
  node_t            cur_node;

  always_comb begin
    r_cur = in_data.first_node ? '0 : row_r;
    c_cur = in_data.first_node ? '0 : col_r;
    r_w   = N_W'(r_cur);
    c_w   = N_W'(c_cur);
    interior  = (r_w >= N_W'(2)) && (r_w <= grid_n - 1'b1) &&
                (c_w >= N_W'(1)) && (c_w <= grid_n - N_W'(2));
    last_node = (r_w == grid_n - 1'b1) && (c_w == grid_n - N_W'(2));
    if (c_w + 1'b1 >= grid_n) begin
      col_nxt = '0;
      row_nxt = (r_w + 1'b1 >= grid_n) ? '0 : r_cur + 1'b1;
    end else begin
      col_nxt = c_cur + 1'b1;
      row_nxt = r_cur;
    end
    cur_node = '{sv: in_data.stream_value, sx: in_data.stream_slope_x,
                 sy: in_data.stream_slope_y, sc: in_data.stream_cross,
                 vv: in_data.vort_value, vx: in_data.vort_slope_x,
                 vy: in_data.vort_slope_y, vc: in_data.vort_cross};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------- line RAMs ----------------
  // own row parity: write and read column c (old row two above, read before overwrite)
  // other parity: read column c+1 (east neighbour of the row above)
  node_t ram_rd [2];

  for (genvar g = 0; g < 2; g++) begin : g_line
    logic [CNT_W-1:0] rd_addr;
    assign rd_addr = (r_cur[0] == 1'(g)) ? c_cur : c_cur + 1'b1;
    hsj_ram #(.WIDTH($bits(node_t)), .DEPTH(GRID_MAX)) u_ram (
      .clk     (clk),
      .wr_en   (accept && (r_cur[0] == 1'(g))),
      .wr_addr (c_cur),
      .wr_data (cur_node),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd[g])
    );
  end

  // column 0 of each row parity, used as west neighbour for column 1
  node_t col0_r [2];
  always_ff @(posedge clk) begin
    if (accept && c_cur == '0) col0_r[r_cur[0]] <= cur_node;
  end

  // ---------------- stage B: RAM read data ----------------
  logic  b_par_r, b_int_r, b_col1_r;
  meta_t b_meta_r;
  node_t b_cur_r, win_ctr_r, win_west_r;
  node_t old_n, east_n, west_n, ctr_n;

  always_ff @(posedge clk) begin
    if (accept) begin
      b_par_r  <= r_cur[0];
      b_int_r  <= interior;
      b_col1_r <= (c_cur == CNT_W'(1));
      b_cur_r  <= cur_node;
      b_meta_r <= '{row: 6'(r_cur - 1'b1), col: 6'(c_cur), last: last_node};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_b_r <= 1'b0;
    else if (rdy_b) v_b_r <= in_valid;
  end

  assign old_n  = ram_rd[b_par_r];
  assign east_n = ram_rd[~b_par_r];
  assign ctr_n  = win_ctr_r;
  assign west_n = b_col1_r ? col0_r[~b_par_r] : win_west_r;

  // advance the neighbour window as each node leaves stage B
  always_ff @(posedge clk) begin
    if (v_b_r && rdy_c) begin
      win_west_r <= win_ctr_r;
      win_ctr_r  <= east_n;
    end
  end

  // ---------------- stage C: differences ----------------
  // lanes 0..3: psi_xx, psi_yy, w_xx, w_yy (and the matching half differences)
  q_t fp [4], fc [4], fm [4], dp [4], dm [4], hp [4], hm [4];
  logic signed [32:0] dd [4];
  q_t    c_s_r [4], c_dq_r [4], c_h_r [4];
  node_t c_ctr_r;
  meta_t c_meta_r;

  always_comb begin
    fp[0] = b_cur_r.sv; fc[0] = ctr_n.sv; fm[0] = old_n.sv;
    dp[0] = b_cur_r.sx; dm[0] = old_n.sx;
    fp[1] = east_n.sv;  fc[1] = ctr_n.sv; fm[1] = west_n.sv;
    dp[1] = east_n.sy;  dm[1] = west_n.sy;
    fp[2] = b_cur_r.vv; fc[2] = ctr_n.vv; fm[2] = old_n.vv;
    dp[2] = b_cur_r.vx; dm[2] = old_n.vx;
    fp[3] = east_n.vv;  fc[3] = ctr_n.vv; fm[3] = west_n.vv;
    dp[3] = east_n.vy;  dm[3] = west_n.vy;
    hp[0] = b_cur_r.sc; hm[0] = old_n.sc;
    hp[1] = east_n.sc;  hm[1] = west_n.sc;
    hp[2] = b_cur_r.vc; hm[2] = old_n.vc;
    hp[3] = east_n.vc;  hm[3] = west_n.vc;
    for (int i = 0; i < 4; i++) begin
      dd[i] = 33'(dp[i]) - 33'(dm[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      for (int i = 0; i < 4; i++) begin
        c_s_r[i]  <= sat32(64'(fp[i]) - (64'(fc[i]) <<< 1) + 64'(fm[i]));
        c_dq_r[i] <= 32'(dd[i] >>> 2);
        c_h_r[i]  <= sat32(64'(hp[i]) - 64'(hm[i]));
      end
      c_ctr_r  <= ctr_n;
      c_meta_r <= b_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_c_r <= 1'b0;
    else if (rdy_c) v_c_r <= v_b_r && b_int_r;
  end

  // ---------------- stage D: scale by 1/h ----------------
  prod_t d_p_r [4];
  q_t    d_dq_r [4], d_h_r [4];
  node_t d_ctr_r;
  meta_t d_meta_r;
  logic signed [63:0] hprod [4];

  always_comb begin
    for (int i = 0; i < 4; i++) hprod[i] = 64'(ihq) * 64'(c_h_r[i]);
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      for (int i = 0; i < 4; i++) begin
        d_p_r[i]  <= 48'(qmul(ihq, c_s_r[i]));
        d_dq_r[i] <= c_dq_r[i];
        d_h_r[i]  <= sat32(hprod[i] >>> (FRAC_BITS + 1));
      end
      d_ctr_r  <= c_ctr_r;
      d_meta_r <= c_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_d_r <= 1'b0;
    else if (rdy_d) v_d_r <= v_c_r;
  end

  // ---------------- stage E: bracketed Hermite term ----------------
  q_t    e_t_r [4], e_h_r [4];
  node_t e_ctr_r;
  meta_t e_meta_r;

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      for (int i = 0; i < 4; i++) begin
        e_t_r[i] <= sat32(64'(d_p_r[i]) - 64'(d_dq_r[i]));
        e_h_r[i] <= d_h_r[i];
      end
      e_ctr_r  <= d_ctr_r;
      e_meta_r <= d_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_e_r <= 1'b0;
    else if (rdy_e) v_e_r <= v_d_r;
  end

  // ---------------- stage F: second derivatives ----------------
  q_t    f_sd_r [4], f_h_r [4];
  node_t f_ctr_r;
  meta_t f_meta_r;

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      for (int i = 0; i < 4; i++) begin
        f_sd_r[i] <= sat32(qmul(ihq, e_t_r[i]));
        f_h_r[i]  <= e_h_r[i];
      end
      f_ctr_r  <= e_ctr_r;
      f_meta_r <= e_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_f_r <= 1'b0;
    else if (rdy_f) v_f_r <= v_e_r;
  end

  // ---------------- stage G: Jacobian products ----------------
  prod_t g_p_r [16];
  meta_t g_meta_r;

  always_ff @(posedge clk) begin
    if (rdy_g) begin
      // value
      g_p_r[0]  <= 48'(qmul(f_ctr_r.sy, f_ctr_r.vx));
      g_p_r[1]  <= 48'(qmul(f_ctr_r.sx, f_ctr_r.vy));
      // x slope
      g_p_r[2]  <= 48'(qmul(f_ctr_r.sc, f_ctr_r.vx));
      g_p_r[3]  <= 48'(qmul(f_ctr_r.sy, f_sd_r[2]));
      g_p_r[4]  <= 48'(qmul(f_sd_r[0], f_ctr_r.vy));
      g_p_r[5]  <= 48'(qmul(f_ctr_r.sx, f_ctr_r.vc));
      // y slope
      g_p_r[6]  <= 48'(qmul(f_sd_r[1], f_ctr_r.vx));
      g_p_r[7]  <= 48'(qmul(f_ctr_r.sy, f_ctr_r.vc));
      g_p_r[8]  <= 48'(qmul(f_ctr_r.sc, f_ctr_r.vy));
      g_p_r[9]  <= 48'(qmul(f_ctr_r.sx, f_sd_r[3]));
      // cross
      g_p_r[10] <= 48'(qmul(f_h_r[1], f_ctr_r.vx));
      g_p_r[11] <= 48'(qmul(f_sd_r[2], f_sd_r[1]));
      g_p_r[12] <= 48'(qmul(f_ctr_r.sy, f_h_r[2]));
      g_p_r[13] <= 48'(qmul(f_h_r[0], f_ctr_r.vy));
      g_p_r[14] <= 48'(qmul(f_sd_r[3], f_sd_r[0]));
      g_p_r[15] <= 48'(qmul(f_ctr_r.sx, f_h_r[3]));
      g_meta_r  <= f_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_g_r <= 1'b0;
    else if (rdy_g) v_g_r <= v_f_r;
  end

  // ---------------- stage H: sums ----------------
  q_t    h_acc_r [4];
  meta_t h_meta_r;

  always_ff @(posedge clk) begin
    if (rdy_h) begin
      h_acc_r[0] <= sat32(64'(g_p_r[0]) - 64'(g_p_r[1]));
      h_acc_r[1] <= sat32(64'(g_p_r[2]) + 64'(g_p_r[3]) - 64'(g_p_r[4]) - 64'(g_p_r[5]));
      h_acc_r[2] <= sat32(64'(g_p_r[6]) + 64'(g_p_r[7]) - 64'(g_p_r[8]) - 64'(g_p_r[9]));
      h_acc_r[3] <= sat32(64'(g_p_r[10]) + 64'(g_p_r[11]) + 64'(g_p_r[12])
                          - 64'(g_p_r[13]) - 64'(g_p_r[14]) - 64'(g_p_r[15]));
      h_meta_r   <= g_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_h_r <= 1'b0;
    else if (rdy_h) v_h_r <= v_g_r;
  end

  // ---------------- output register: Reynolds scaling ----------------
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_data_r.force_value   <= sat32(qmul(req, h_acc_r[0]));
      out_data_r.force_slope_x <= sat32(qmul(req, h_acc_r[1]));
      out_data_r.force_slope_y <= sat32(qmul(req, h_acc_r[2]));
      out_data_r.force_cross   <= sat32(qmul(req, h_acc_r[3]));
      out_data_r.center_row    <= h_meta_r.row;
      out_data_r.center_col    <= h_meta_r.col;
      out_data_r.last_of_grid  <= h_meta_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (rdy_o) out_valid_r <= v_h_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/hsj_checker.sv
// Port-level checks for the Hermite stencil Jacobian block, bound to its top level.
// Depends on hsj_pkg and hermite_stencil_jacobian_force.
`default_nettype none
module hsj_checker import hsj_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire out_t        out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  // no result beat straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // no result beat has its centre in row 0 or column 0
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.center_row != 6'd0 && out_data.center_col != 6'd0))
    else $error("boundary centre emitted");

  // the last centre of a grid sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_grid) |-> (out_data.center_row == out_data.center_col))
    else $error("last_of_grid off the diagonal");

  // input back-pressure only when a result beat is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result beat");

endmodule

bind hermite_stencil_jacobian_force hsj_checker u_hsj_checker (.*);
`default_nettype wire
